FILE: sv/fssg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fssg_pkg
// Shared types and constants for the frame strip and sequence gap block.
// ----------------------------------------------------------------------------
package fssg_pkg;

    localparam int DEFAULT_HEADER_BYTES  = 14;
    localparam int DEFAULT_TRAILER_BYTES = 4;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [15:0] packet_number;
        logic [15:0] lost_packets;
        logic        first_frame;
        logic        short_frame;
    } fssg_result_t;

endpackage
`default_nettype wire

FILE: sv/frame_strip_and_sequence_gap.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frame_strip_and_sequence_gap
// Usage:
//   Byte channel (byte_valid/byte_ready) carries raw frame bytes with
//   end_of_frame set on the last byte. The header is dropped and the
//   trailer is held back in a delay line; middle bytes leave on the result
//   channel (result_valid/result_ready) with kind = payload. The last byte
//   of a frame adds a summary transaction with the big-endian packet
//   number from the last two bytes and the gap to the previous good frame.
//   Each result is written into the queue when its byte is accepted.
//   Throughput: one byte per cycle while byte_ready is high. A byte
//   yields zero, one or two results; results go through a 4-entry queue
//   drained one per cycle while result_ready is high, and byte_ready is
//   low while fewer than two entries are free. With the receiver always
//   ready the queue never holds more than two entries, so byte_ready stays
//   high and no cycle is lost. A stall on the result side fills the queue
//   and then holds byte_ready low; nothing is dropped.
//   Reset clears the position counter, delay line, previous number, the
//   good-frame flag and the queue; the first good frame reports a gap of 0.
// ----------------------------------------------------------------------------
module frame_strip_and_sequence_gap #(
    parameter int HEADER_BYTES  = fssg_pkg::DEFAULT_HEADER_BYTES,
    parameter int TRAILER_BYTES = fssg_pkg::DEFAULT_TRAILER_BYTES
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        byte_valid,
    output logic             byte_ready,
    input  wire logic [7:0]  in_byte,
    input  wire logic        end_of_frame,
    output logic             result_valid,
    input  wire logic        result_ready,
    output logic             kind,
    output logic [7:0]       payload_byte,
    output logic [15:0]      packet_number,
    output logic [15:0]      lost_packets,
    output logic             first_frame,
    output logic             short_frame
);
    import fssg_pkg::*;

    localparam int MIN_FRAME = HEADER_BYTES + TRAILER_BYTES;
    localparam int POS_W     = $clog2(MIN_FRAME + 1);
    localparam int Q_DEPTH   = 4;
    localparam int PTR_W     = $clog2(Q_DEPTH);
    localparam int CNT_W     = $clog2(Q_DEPTH + 1);

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [7:0]        delay_reg [TRAILER_BYTES];
    logic [15:0]       prev_reg, prev_next;
    logic              have_prev_reg, have_prev_next;

    fssg_result_t      queue_reg [Q_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    logic              accept, pop;
    logic              emit_pay, is_short;
    logic [15:0]       num, gap;
    fssg_result_t      pay_res, sum_res, slot0, slot1;
    logic [1:0]        push_n;
    fssg_result_t      head;

    assign accept = byte_valid && byte_ready;
    assign pop    = result_valid && result_ready;

    assign byte_ready = (count_reg <= CNT_W'(Q_DEPTH - 2));

    assign emit_pay = (pos_reg == POS_W'(MIN_FRAME));
    assign is_short = (pos_reg < POS_W'(MIN_FRAME - 1));
    assign num      = {delay_reg[0], in_byte};
    assign gap      = num - prev_reg - 16'd1;

    always_comb
    begin
        pay_res               = '0;
        pay_res.kind          = KIND_PAYLOAD;
        pay_res.payload_byte  = delay_reg[TRAILER_BYTES-1];

        sum_res               = '0;
        sum_res.kind          = KIND_SUMMARY;
        sum_res.first_frame   = !have_prev_reg;
        sum_res.short_frame   = is_short;
        if (!is_short)
        begin
            sum_res.packet_number = num;
            sum_res.lost_packets  = have_prev_reg ? gap : 16'd0;
        end

        slot0  = emit_pay ? pay_res : sum_res;
        slot1  = sum_res;
        push_n = 2'(emit_pay) + 2'(end_of_frame);
    end

    always_comb
    begin
        pos_next       = pos_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        if (end_of_frame)
        begin
            pos_next = '0;
            if (!is_short)
            begin
                prev_next      = num;
                have_prev_next = 1'b1;
            end
        end
        else if (pos_reg < POS_W'(MIN_FRAME))
        begin
            pos_next = pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            for (int i = 0; i < TRAILER_BYTES; i++)
            begin
                delay_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            pos_reg       <= pos_next;
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
            delay_reg[0]  <= in_byte;
            for (int i = 1; i < TRAILER_BYTES; i++)
            begin
                delay_reg[i] <= delay_reg[i-1];
            end
        end
    end

    // Result queue
    always_ff @(posedge clk)
    begin
        if (accept && (push_n != 2'd0))
        begin
            queue_reg[wr_ptr_reg] <= slot0;
        end
        if (accept && (push_n == 2'd2))
        begin
            queue_reg[wr_ptr_reg + PTR_W'(1)] <= slot1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_n);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_reg + (accept ? CNT_W'(push_n) : CNT_W'(0))
                         - CNT_W'(pop);
        end
    end

    assign head          = queue_reg[rd_ptr_reg];
    assign result_valid  = (count_reg != '0);
    assign kind          = head.kind;
    assign payload_byte  = head.payload_byte;
    assign packet_number = head.packet_number;
    assign lost_packets  = head.lost_packets;
    assign first_frame   = head.first_frame;
    assign short_frame   = head.short_frame;

endmodule
`default_nettype wire

FILE: sv/fssg_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fssg_checker
// Port-level checks for the frame strip and sequence gap block.
// ----------------------------------------------------------------------------
module fssg_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        byte_valid,
    input wire logic        byte_ready,
    input wire logic [7:0]  in_byte,
    input wire logic        end_of_frame,
    input wire logic        result_valid,
    input wire logic        result_ready,
    input wire logic        kind,
    input wire logic [7:0]  payload_byte,
    input wire logic [15:0] packet_number,
    input wire logic [15:0] lost_packets,
    input wire logic        first_frame,
    input wire logic        short_frame
);
    import fssg_pkg::*;

    a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && kind == KIND_PAYLOAD) |->
        (packet_number == 16'd0 && lost_packets == 16'd0 && !first_frame && !short_frame))
        else $error("payload transaction carries summary fields");

    a_summary_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && kind == KIND_SUMMARY) |-> (payload_byte == 8'd0))
        else $error("summary transaction carries a payload byte");

    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && short_frame) |-> (packet_number == 16'd0 && lost_packets == 16'd0))
        else $error("short frame reports a packet number or gap");

    a_first_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && first_frame) |-> (lost_packets == 16'd0))
        else $error("first frame reports a gap");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=>
        (result_valid && $stable(kind) && $stable(payload_byte) && $stable(packet_number)))
        else $error("stalled result transaction changed");

endmodule

bind frame_strip_and_sequence_gap fssg_checker u_fssg_checker (.*);
`default_nettype wire

FILE: test/frame_strip_and_sequence_gap_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_strip_and_sequence_gap_tb
// Feeds frames one byte at a time and checks every result transaction
// against a local deframer predictor: the header is dropped, the trailer is
// held back, payload bytes pass, and each frame end gives a summary with the
// packet number and the gap to the previous good frame. A short directed
// table with hand-typed summaries comes first. Random frames follow, of
// mixed length, with numbers that repeat, advance, skip and wrap. Idle
// cycles fall on both sides, weighted first toward the receiver, then toward the sender, and then on neither.
// ----------------------------------------------------------------------------
module frame_strip_and_sequence_gap_tb;
    import fssg_pkg::*;

    localparam int MIN_FRAME       = DEFAULT_HEADER_BYTES + DEFAULT_TRAILER_BYTES;
    localparam int ITEMS_PER_PHASE = 450;

    typedef struct packed {
        logic [7:0]   in_byte;
        logic         eof;
        logic         typed;
        fssg_result_t summary;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        byte_valid;
    logic        byte_ready;
    logic [7:0]  in_byte;
    logic        end_of_frame;
    logic        result_valid;
    logic        result_ready;
    logic        kind;
    logic [7:0]  payload_byte;
    logic [15:0] packet_number;
    logic [15:0] lost_packets;
    logic        first_frame;
    logic        short_frame;

    logic [7:0]   trailer_bytes [DEFAULT_TRAILER_BYTES];
    int           frame_pos;
    logic [15:0]  last_number;
    logic         seen_good;
    fssg_result_t expected_results [$];
    stim_row_t    directed_rows [25];
    int           mismatch_count;
    int           sender_idle_pct;
    int           receiver_idle_pct;

    frame_strip_and_sequence_gap dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .byte_ready    (byte_ready),
        .in_byte       (in_byte),
        .end_of_frame  (end_of_frame),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .kind          (kind),
        .payload_byte  (payload_byte),
        .packet_number (packet_number),
        .lost_packets  (lost_packets),
        .first_frame   (first_frame),
        .short_frame   (short_frame)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    task predict_deframe(input logic [7:0] b, input logic eof);
        fssg_result_t r;
        logic [15:0]  number;
        logic [7:0]   prior;
        prior = trailer_bytes[0];
        if (frame_pos >= MIN_FRAME)
        begin
            r = '0;
            r.kind = KIND_PAYLOAD;
            r.payload_byte = trailer_bytes[DEFAULT_TRAILER_BYTES - 1];
            expected_results.push_back(r);
        end
        for (int i = DEFAULT_TRAILER_BYTES - 1; i > 0; i--)
            trailer_bytes[i] = trailer_bytes[i - 1];
        trailer_bytes[0] = b;
        if (eof)
        begin
            r = '0;
            r.kind = KIND_SUMMARY;
            r.first_frame = !seen_good;
            if (frame_pos + 1 < MIN_FRAME)
                r.short_frame = 1'b1;
            else
            begin
                number = {prior, b};
                r.packet_number = number;
                if (seen_good)
                    r.lost_packets = number - last_number - 16'd1;
                last_number = number;
                seen_good = 1'b1;
            end
            expected_results.push_back(r);
            frame_pos = 0;
        end
        else if (frame_pos < MIN_FRAME)
            frame_pos++;
    endtask

    task send_byte(input logic [7:0] b, input logic eof);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid   <= 1'b1;
        in_byte      <= b;
        end_of_frame <= eof;
        do
            @(posedge clk);
        while (!byte_ready);
        predict_deframe(b, eof);
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        fssg_result_t want;
        result_ready <= ($urandom_range(99) >= receiver_idle_pct);
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result transaction kind %0d byte %0d number %0d",
                         $time, kind, payload_byte, packet_number);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                compare_field("kind", want.kind, kind);
                compare_field("payload_byte", want.payload_byte, payload_byte);
                compare_field("packet_number", want.packet_number, packet_number);
                compare_field("lost_packets", want.lost_packets, lost_packets);
                compare_field("first_frame", want.first_frame, first_frame);
                compare_field("short_frame", want.short_frame, short_frame);
            end
        end
    end

    initial
    begin
        int          phase;
        int          items;
        int          len;
        int          sel;
        int          wait_cycles;
        logic [15:0] number;
        logic [7:0]  b;

        rst_n             = 1'b0;
        byte_valid        = 1'b0;
        in_byte           = 8'h00;
        end_of_frame      = 1'b0;
        result_ready      = 1'b0;
        mismatch_count    = 0;
        sender_idle_pct   = 27;
        receiver_idle_pct = 55;
        frame_pos         = 0;
        last_number       = 16'h0000;
        seen_good         = 1'b0;
        foreach (trailer_bytes[i])
            trailer_bytes[i] = 8'h00;

        directed_rows = '{
            '{8'hA5, 1'b1, 1'b1, '{KIND_SUMMARY, 8'h00, 16'h0000, 16'h0000, 1'b1, 1'b1}},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, '0},
            '{8'h55, 1'b0, 1'b0, '0},
            '{8'hAA, 1'b0, 1'b0, '0},
            '{8'h01, 1'b0, 1'b0, '0},
            '{8'h80, 1'b0, 1'b0, '0},
            '{8'h02, 1'b0, 1'b0, '0},
            '{8'h40, 1'b0, 1'b0, '0},
            '{8'h04, 1'b0, 1'b0, '0},
            '{8'h20, 1'b0, 1'b0, '0},
            '{8'h08, 1'b0, 1'b0, '0},
            '{8'h10, 1'b0, 1'b0, '0},
            '{8'hFE, 1'b0, 1'b0, '0},
            '{8'h7F, 1'b0, 1'b0, '0},
            '{8'hC3, 1'b0, 1'b0, '0},
            '{8'h3C, 1'b0, 1'b0, '0},
            '{8'h99, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b1, 1'b1, '{KIND_SUMMARY, 8'h00, 16'hFFFF, 16'h0000, 1'b1, 1'b0}},
            '{8'h11, 1'b0, 1'b0, '0},
            '{8'h22, 1'b0, 1'b0, '0},
            '{8'h33, 1'b0, 1'b0, '0},
            '{8'h44, 1'b0, 1'b0, '0},
            '{8'h55, 1'b1, 1'b1, '{KIND_SUMMARY, 8'h00, 16'h0000, 16'h0000, 1'b0, 1'b1}}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[row])
        begin
            send_byte(directed_rows[row].in_byte, directed_rows[row].eof);
            if (directed_rows[row].typed)
                expected_results[expected_results.size() - 1] = directed_rows[row].summary;
        end

        for (phase = 0; phase < 3; phase++)
        begin
            byte_valid <= 1'b0;
            do
                @(posedge clk);
            while (expected_results.size() != 0);

            case (phase)
                0:
                begin
                    sender_idle_pct   = 27;
                    receiver_idle_pct = 55;
                end
                1:
                begin
                    sender_idle_pct   = 55;
                    receiver_idle_pct = 27;
                end
                default:
                begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                end
            endcase

            items = 0;
            while (items < ITEMS_PER_PHASE)
            begin
                sel = $urandom_range(99);
                if (sel < 12)
                    len = $urandom_range(MIN_FRAME - 1, 1);
                else if (sel < 20)
                    len = MIN_FRAME + $urandom_range(1, 0);
                else if (sel < 92)
                    len = $urandom_range(40, MIN_FRAME + 2);
                else
                    len = $urandom_range(160, 41);

                sel = $urandom_range(99);
                if (sel < 45)
                    number = last_number + 16'd1;
                else if (sel < 55)
                    number = last_number;
                else if (sel < 65)
                    number = last_number + 16'($urandom_range(9, 2));
                else if (sel < 75)
                    number = last_number - 16'($urandom_range(300, 1));
                else if (sel < 80)
                    number = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                else
                    number = 16'($urandom);

                for (int i = 0; i < len; i++)
                begin
                    if (i == len - 1)
                        b = number[7:0];
                    else if (i == len - 2)
                        b = number[15:8];
                    else
                        b = 8'($urandom);
                    send_byte(b, i == len - 1);
                    items++;
                end
            end
        end

        byte_valid <= 1'b0;
        wait_cycles = 0;
        do
        begin
            @(posedge clk);
            wait_cycles++;
        end
        while (expected_results.size() != 0 && wait_cycles < 5000);
        repeat (10) @(posedge clk);

        if (expected_results.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, expected_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
